// ===== src/sha_pkg.sv =====
// Shared types and codes for the stamped handle allocator.
`timescale 1ns / 1ps

package sha_pkg;

  localparam int STATUS_BITS = 3;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK             = 3'd0,
    ST_ELEM_EXHAUSTED = 3'd1,
    ST_PORT_EXHAUSTED = 3'd2,
    ST_QUEUE_FULL     = 3'd3,
    ST_BAD_HANDLE     = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Free queue request from the allocator, one pool per item.
  typedef struct packed {
    logic push;
    logic pop;
    logic pool;
  } q_cmd_t;

  // Free queue occupancy, bit 0 element pool, bit 1 port pool.
  typedef struct packed {
    logic [1:0] empty;
    logic [1:0] full;
  } q_stat_t;

endpackage

// ===== src/sha_if.sv =====
// Request and response channel interfaces of the stamped handle allocator.
`timescale 1ns / 1ps

interface sha_req_if #(
  parameter int HANDLE_BITS = 18,
  parameter int ID_BITS     = 16
);
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic                   is_port;
  logic [ID_BITS-1:0]     element_id;
  logic [HANDLE_BITS-1:0] handle;
  logic [31:0]            now;

  modport source (output valid, cmd, is_port, element_id, handle, now, input ready);
  modport sink (input valid, cmd, is_port, element_id, handle, now, output ready);
endinterface

interface sha_rsp_if #(
  parameter int HANDLE_BITS = 18
);
  logic                             valid;
  logic                             ready;
  logic [HANDLE_BITS-1:0]           new_handle;
  logic [sha_pkg::STATUS_BITS-1:0]  status;

  modport source (output valid, new_handle, status, input ready);
  modport sink (input valid, new_handle, status, output ready);
endinterface

// ===== src/sha_free_queue.sv =====
// Freed-handle FIFOs for both pools, sharing one memory split by pool.
`timescale 1ns / 1ps

module sha_free_queue #(
  parameter int HANDLE_BITS = 18,
  parameter int DEPTH       = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic                   rd_pool,
  input  sha_pkg::q_cmd_t        cmd,
  input  logic [HANDLE_BITS-1:0] push_handle,
  input  logic [31:0]            push_time,
  output logic [HANDLE_BITS-1:0] head_handle,
  output logic [31:0]            head_time,
  output sha_pkg::q_stat_t       stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [31:0]            when;
  } entry_t;

  entry_t           mem [2**(PTR_W+1)];
  entry_t           rd_data;
  logic [PTR_W-1:0] head [2];
  logic [PTR_W-1:0] tail [2];
  logic [CNT_W-1:0] count [2];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[{cmd.pool, tail[cmd.pool]}] <= '{handle: push_handle, when: push_time};
    end
    if (rd_en) begin
      rd_data <= mem[{rd_pool, head[rd_pool]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 2; p++) begin
        head[p]  <= '0;
        tail[p]  <= '0;
        count[p] <= '0;
      end
    end else begin
      if (cmd.push) begin
        tail[cmd.pool]  <= (tail[cmd.pool] == LAST_PTR) ? '0 : tail[cmd.pool] + 1'b1;
        count[cmd.pool] <= count[cmd.pool] + 1'b1;
      end else if (cmd.pop) begin
        head[cmd.pool]  <= (head[cmd.pool] == LAST_PTR) ? '0 : head[cmd.pool] + 1'b1;
        count[cmd.pool] <= count[cmd.pool] - 1'b1;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      stat.empty[p] = (count[p] == '0);
      stat.full[p]  = (count[p] == FULL_CNT);
    end
  end

  assign head_handle = rd_data.handle;
  assign head_time   = rd_data.when;

endmodule

// ===== src/stamped_handle_allocator.sv =====
// Generational handle allocator with delayed reuse of freed slots, two pools.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    cmd, is_port, element_id, handle, now
//   rsp      out  valid/ready    new_handle, status
//   cfg      in   cfg_wr_en      cfg_wr_data (reuse_delay)
//
// An item is accepted in the idle state, which reads the slot memory and the
// free queue head; the execute state then does the read-modify-write, as
// those memories have registered reads.
// No clearing pass after reset: slots beyond the fresh counters read as empty.
// The execute cycle waits while the previous result is still held in rsp.
`timescale 1ns / 1ps

module stamped_handle_allocator #(
  parameter int INDEX_BITS       = 10,
  parameter int STAMP_BITS       = 8,
  parameter int FIRST_PORT_SLOT  = 512,
  parameter int FREE_QUEUE_DEPTH = 256,
  parameter int ELEMENT_ID_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  sha_req_if.sink     req,
  sha_rsp_if.source   rsp
);

  localparam int HANDLE_BITS = INDEX_BITS + STAMP_BITS;
  localparam int CNT_W       = INDEX_BITS + 1;
  localparam int SLOT_COUNT  = 2**INDEX_BITS;
  localparam int PORT_BASE   = (FIRST_PORT_SLOT < SLOT_COUNT) ? FIRST_PORT_SLOT : SLOT_COUNT;
  localparam logic [CNT_W-1:0] SLOT_COUNT_C = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] PORT_BASE_C  = CNT_W'(PORT_BASE);

  typedef struct packed {
    logic                       valid;
    logic [STAMP_BITS-1:0]      stamp;
    logic [ELEMENT_ID_BITS-1:0] id;
  } slot_t;

  sha_pkg::state_t state, state_next;
  logic            req_ready;
  logic            exec_go;
  logic            in_fire;

  logic [31:0] reuse_delay;

  // Accepted item
  logic                       cmd_q;
  logic                       is_port_q;
  logic [ELEMENT_ID_BITS-1:0] id_q;
  logic [HANDLE_BITS-1:0]     handle_q;
  logic [31:0]                now_q;

  slot_t                 slot_mem [SLOT_COUNT];
  slot_t                 slot_rd;
  logic                  slot_we;
  logic [INDEX_BITS-1:0] slot_waddr;
  slot_t                 slot_wdata;

  logic [CNT_W-1:0] next_elem, next_elem_next;
  logic [CNT_W-1:0] next_port, next_port_next;

  sha_pkg::q_cmd_t        q_cmd;
  sha_pkg::q_stat_t       q_stat;
  logic [HANDLE_BITS-1:0] head_handle;
  logic [31:0]            head_time;

  logic                   out_valid;
  logic [HANDLE_BITS-1:0] out_handle, out_handle_next;
  sha_pkg::status_t       out_status, out_status_next;

  logic                  head_ok;
  logic [INDEX_BITS-1:0] rm_idx;
  logic [CNT_W-1:0]      rm_ext;
  logic                  rm_known;
  logic                  rm_pool;
  logic [CNT_W-1:0]      fresh_ctr;
  logic                  fresh_out;
  logic [STAMP_BITS-1:0] reuse_stamp;

  assign in_fire = req.valid && req_ready;

  // Control

  always_comb begin
    state_next = state;
    case (state)
      sha_pkg::S_IDLE: if (req.valid) state_next = sha_pkg::S_EXEC;
      sha_pkg::S_EXEC: if (exec_go) state_next = sha_pkg::S_IDLE;
      default:         state_next = sha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    exec_go   = 1'b0;
    case (state)
      sha_pkg::S_IDLE: req_ready = 1'b1;
      sha_pkg::S_EXEC: exec_go = !out_valid || rsp.ready;
      default:         req_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha_pkg::S_IDLE;
      reuse_delay <= 32'd1000;
      next_elem   <= CNT_W'(1);
      next_port   <= PORT_BASE_C;
    end else begin
      state     <= state_next;
      next_elem <= next_elem_next;
      next_port <= next_port_next;
      if (cfg_wr_en) begin
        reuse_delay <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q     <= req.cmd;
      is_port_q <= req.is_port;
      id_q      <= req.element_id;
      handle_q  <= req.handle;
      now_q     <= req.now;
    end
  end

  // Slot memory: read on accept, write back in the execute cycle

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (in_fire) begin
      slot_rd <= slot_mem[req.handle[HANDLE_BITS-1 -: INDEX_BITS]];
    end
  end

  sha_free_queue #(
    .HANDLE_BITS (HANDLE_BITS),
    .DEPTH       (FREE_QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (in_fire),
    .rd_pool     (req.is_port),
    .cmd         (q_cmd),
    .push_handle (handle_q),
    .push_time   (now_q),
    .head_handle (head_handle),
    .head_time   (head_time),
    .stat        (q_stat)
  );

  // Execute

  always_comb begin
    head_ok     = !q_stat.empty[is_port_q] && ((now_q - head_time) > reuse_delay);
    reuse_stamp = head_handle[STAMP_BITS-1:0] + 1'b1;
    fresh_ctr   = is_port_q ? next_port : next_elem;
    fresh_out   = is_port_q ? (next_port >= SLOT_COUNT_C) : (next_elem >= PORT_BASE_C);

    rm_idx   = handle_q[HANDLE_BITS-1 -: INDEX_BITS];
    rm_ext   = {1'b0, rm_idx};
    rm_pool  = (rm_ext >= PORT_BASE_C);
    // Slots never handed out fresh were never written: treat them as empty
    rm_known = ((rm_idx != '0) && (rm_ext < next_elem))
            || (rm_pool && (rm_ext < next_port));

    next_elem_next  = next_elem;
    next_port_next  = next_port;
    slot_we         = 1'b0;
    slot_waddr      = rm_idx;
    slot_wdata      = '0;
    q_cmd           = '0;
    out_handle_next = '0;
    out_status_next = sha_pkg::ST_OK;

    if (exec_go) begin
      if (cmd_q == sha_pkg::CMD_ADD) begin
        q_cmd.pool = is_port_q;
        if (head_ok) begin
          q_cmd.pop       = 1'b1;
          slot_we         = 1'b1;
          slot_waddr      = head_handle[HANDLE_BITS-1 -: INDEX_BITS];
          slot_wdata      = '{valid: 1'b1, stamp: reuse_stamp, id: id_q};
          out_handle_next = {head_handle[HANDLE_BITS-1 -: INDEX_BITS], reuse_stamp};
        end else if (fresh_out) begin
          out_status_next = is_port_q ? sha_pkg::ST_PORT_EXHAUSTED
                                      : sha_pkg::ST_ELEM_EXHAUSTED;
        end else begin
          slot_we         = 1'b1;
          slot_waddr      = fresh_ctr[INDEX_BITS-1:0];
          slot_wdata      = '{valid: 1'b1, stamp: '0, id: id_q};
          out_handle_next = {fresh_ctr[INDEX_BITS-1:0], {STAMP_BITS{1'b0}}};
          if (is_port_q) begin
            next_port_next = next_port + 1'b1;
          end else begin
            next_elem_next = next_elem + 1'b1;
          end
        end
      end else begin
        q_cmd.pool = rm_pool;
        if (!(rm_known && slot_rd.valid && (slot_rd.stamp == handle_q[STAMP_BITS-1:0]))) begin
          out_status_next = sha_pkg::ST_BAD_HANDLE;
        end else begin
          // Clear the slot even when the queue is full: it retires for good
          slot_we = 1'b1;
          if (q_stat.full[rm_pool]) begin
            out_status_next = sha_pkg::ST_QUEUE_FULL;
          end else begin
            q_cmd.push = 1'b1;
          end
        end
      end
    end
  end

  // Result register

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_handle <= out_handle_next;
      out_status <= out_status_next;
    end
  end

  assign req.ready      = req_ready;
  assign rsp.valid      = out_valid;
  assign rsp.new_handle = out_handle;
  assign rsp.status     = out_status;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == sha_pkg::S_EXEC)
    else $error("accepted item did not enter execute");

  a_counters_bounded: assert property (@(posedge clk) disable iff (rst)
    (next_elem <= PORT_BASE_C) && (next_port <= SLOT_COUNT_C) && (next_port >= PORT_BASE_C))
    else $error("fresh slot counter out of its pool");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_cmd.push |-> !q_stat.full[q_cmd.pool])
    else $error("push into full free queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_cmd.pop |-> !q_stat.empty[q_cmd.pool] && (cmd_q == sha_pkg::CMD_ADD))
    else $error("pop from empty free queue");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == sha_pkg::S_EXEC))
    else $error("result loaded outside execute");
`endif

endmodule
